[rtl/rhtp_pkg.sv]
// ----------------------------------------------------------------------------
// rhtp_pkg
// Shared constants and control/status types of the recent history track picker.
// ----------------------------------------------------------------------------
package rhtp_pkg;

  localparam int HISTORY_DEPTH = 20;
  localparam int MAX_REDRAWS   = 100;

  localparam int WORD_W  = 31;
  localparam int TRACK_W = 8;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int SPAN_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int BIT_W   = $clog2(WORD_W);

  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  word;
    logic [TRACK_W-1:0] divisor;
  } rhtp_mod_ctl_t;

  typedef struct packed {
    logic               done;
    logic [TRACK_W-1:0] rem;
  } rhtp_mod_sts_t;

  typedef struct packed {
    logic               start;
    logic               wr_en;
    logic [TRACK_W-1:0] cand;
    logic [SPAN_W-1:0]  span;
  } rhtp_hist_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } rhtp_hist_sts_t;

endpackage

[rtl/rhtp_ifs.sv]
// ----------------------------------------------------------------------------
// rhtp_ifs
// Valid/ready channels for draws in and pick results out.
// ----------------------------------------------------------------------------
interface rhtp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rhtp_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

interface rhtp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        chosen;
  logic [rhtp_pkg::TRACK_W-1:0] track_number;
  logic [rhtp_pkg::COUNT_W-1:0] draw_count;
  logic                        forced;

  modport source (output valid, output chosen, output track_number, output draw_count,
                  output forced, input ready);
  modport sink (input valid, input chosen, input track_number, input draw_count,
                input forced, output ready);
endinterface

[rtl/rhtp_mod_unit.sv]
// ----------------------------------------------------------------------------
// rhtp_mod_unit
// Bit-serial restoring modulo: one draw bit per cycle, one compare/subtract.
// ----------------------------------------------------------------------------
module rhtp_mod_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rhtp_pkg::rhtp_mod_ctl_t ctl_i,
  output rhtp_pkg::rhtp_mod_sts_t sts_o
);
  import rhtp_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BIT_W-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [TRACK_W-1:0] div_q, div_d;
  logic [TRACK_W-1:0] rem_q, rem_d;
  logic [TRACK_W:0]   trial;

  assign trial = {rem_q, word_q[WORD_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    word_d = word_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      word_d = ctl_i.word;
      div_d  = ctl_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = TRACK_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[TRACK_W-1:0];
      end
      word_d = {word_q[WORD_W-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == BIT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;

endmodule

[rtl/rhtp_history.sv]
// ----------------------------------------------------------------------------
// rhtp_history
// Ring of played tracks with a backward scan, one entry compared per cycle.
// ----------------------------------------------------------------------------
module rhtp_history (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rhtp_pkg::rhtp_hist_ctl_t ctl_i,
  output rhtp_pkg::rhtp_hist_sts_t sts_o
);
  import rhtp_pkg::*;

  logic [TRACK_W-1:0] ring_q [HISTORY_DEPTH];
  logic [SLOT_W-1:0]  wslot_q;
  logic [SLOT_W-1:0]  pos_q;
  logic [SPAN_W-1:0]  cnt_q;
  logic [SPAN_W-1:0]  span_q;
  logic [TRACK_W-1:0] cand_q;
  logic               busy_q;
  logic               done_q;
  logic               hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        ring_q[k] <= '0;
      end
      wslot_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      span_q  <= '0;
      cand_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.wr_en) begin
        ring_q[wslot_q] <= ctl_i.cand;
        wslot_q <= (wslot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
      end
      if (ctl_i.start) begin
        pos_q  <= (wslot_q == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : wslot_q - 1'b1;
        cnt_q  <= '0;
        span_q <= ctl_i.span;
        cand_q <= ctl_i.cand;
        hit_q  <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == span_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (ring_q[pos_q] == cand_q) begin
          hit_q  <= 1'b1;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          pos_q <= (pos_q == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : pos_q - 1'b1;
        end
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.hit  = hit_q;

endmodule

[rtl/recent_history_track_picker.sv]
// ----------------------------------------------------------------------------
// recent_history_track_picker
// Picks a track from each random draw, rejecting tracks played recently.
// ----------------------------------------------------------------------------
// Each draw gives one result: the candidate 1 + draw mod track_count, with
// chosen set when it is taken into the play history or cleared to ask for
// another draw. From transfer to result a draw passes through the bit-serial
// modulo unit, the start of the history scan, one history compare per cycle
// over up to min(track_count/2, 20) entries, the close of the scan, the
// latching of its outcome and the decision. The input is ready only between
// draws; a finished result waits in the output register while the next draw
// is taken in, and the decision of that next draw holds until the waiting
// result has been transferred.
module recent_history_track_picker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rhtp_pkg::TRACK_W-1:0]  cfg_wdata_i,
  rhtp_in_if.sink                       in_i,
  rhtp_out_if.source                    out_o
);
  import rhtp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MOD    = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [TRACK_W-1:0] track_count_q;
  logic [TRACK_W-1:0] n_eff;
  logic [TRACK_W-1:0] half;
  logic [SPAN_W-1:0]  span;
  logic [TRACK_W-1:0] cand_q, cand_d;
  logic               hit_q, hit_d;
  logic [COUNT_W-1:0] redraws_q, redraws_d;
  logic               out_valid_q, out_valid_d;
  logic               chosen_q, chosen_d;
  logic [TRACK_W-1:0] track_q, track_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               forced_q, forced_d;
  logic               take;
  logic               pick;

  rhtp_mod_ctl_t  mod_ctl;
  rhtp_mod_sts_t  mod_sts;
  rhtp_hist_ctl_t hist_ctl;
  rhtp_hist_sts_t hist_sts;

  rhtp_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mod_ctl),
    .sts_o  (mod_sts)
  );

  rhtp_history u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (hist_ctl),
    .sts_o  (hist_sts)
  );

  assign n_eff = (track_count_q == '0) ? TRACK_W'(1) : track_count_q;
  assign half  = {1'b0, n_eff[TRACK_W-1:1]};
  assign span  = (half > TRACK_W'(HISTORY_DEPTH)) ? SPAN_W'(HISTORY_DEPTH) : SPAN_W'(half);

  assign in_i.ready = (state_q == ST_IDLE);
  assign take       = !out_valid_q || out_o.ready;
  assign pick       = !hit_q || (redraws_q >= COUNT_W'(MAX_REDRAWS));

  assign mod_ctl.start   = in_i.valid && in_i.ready;
  assign mod_ctl.word    = in_i.random_word;
  assign mod_ctl.divisor = n_eff;

  assign hist_ctl.start = (state_q == ST_MOD) && mod_sts.done;
  assign hist_ctl.wr_en = (state_q == ST_DECIDE) && take && pick;
  assign hist_ctl.cand  = (state_q == ST_MOD) ? (mod_sts.rem + 1'b1) : cand_q;
  assign hist_ctl.span  = span;

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    hit_d       = hit_q;
    redraws_d   = redraws_q;
    out_valid_d = out_valid_q && !out_o.ready;
    chosen_d    = chosen_q;
    track_d     = track_q;
    count_d     = count_q;
    forced_d    = forced_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_sts.done) begin
          cand_d  = mod_sts.rem + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hist_sts.done) begin
          hit_d   = hist_sts.hit;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (take) begin
          out_valid_d = 1'b1;
          chosen_d    = pick;
          forced_d    = pick && hit_q;
          track_d     = cand_q;
          count_d     = redraws_q + 1'b1;
          redraws_d   = pick ? '0 : redraws_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      track_count_q <= TRACK_W'(1);
      redraws_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      redraws_q   <= redraws_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        track_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    hit_q    <= hit_d;
    chosen_q <= chosen_d;
    track_q  <= track_d;
    count_q  <= count_d;
    forced_q <= forced_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chosen       = chosen_q;
  assign out_o.track_number = track_q;
  assign out_o.draw_count   = count_q;
  assign out_o.forced       = forced_q;

`ifndef NO_ASSERTIONS
  a_forced_needs_chosen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.forced |-> out_o.chosen)
    else $error("forced result without chosen");

  a_redraw_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    redraws_q <= COUNT_W'(MAX_REDRAWS))
    else $error("redraw count beyond limit");

  a_reject_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.chosen |-> out_o.draw_count <= COUNT_W'(MAX_REDRAWS))
    else $error("rejection after redraw limit");

  a_mod_done_in_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_sts.done |-> state_q == ST_MOD)
    else $error("modulo result outside modulo phase");

  a_transfer_starts_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_MOD)
    else $error("draw transfer did not start modulo");
`endif

endmodule
